@@ rtl/core/ipv6tp_pkg.sv @@
// Package for the IPv6 address text parser core.
// Holds character codes, the hex decode function and the parser snapshot type.
// No dependencies.
`default_nettype none

package ipv6tp_pkg;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;

   localparam int         ADDR_BYTES   = 16;
   localparam logic [4:0] POS_FULL     = 5'd16;
   localparam logic [4:0] POS_LAST_GRP = 5'd14;
   localparam logic [4:0] POS_LAST_V4  = 5'd12;
   localparam logic [8:0] OCTET_MAX    = 9'd255;
   localparam logic [8:0] TOKEN_SAT    = 9'd256;
   localparam logic [2:0] OCTETS_V4    = 3'd4;

   // Parser state after the final character of a string, handed to the finisher.
   typedef struct packed {
      logic [15:0][7:0] bytes;
      logic [4:0]       write_pos;
      logic [4:0]       gap_pos;
      logic             gap_seen;
      logic [15:0]      group_value;
      logic             group_has_digit;
      logic             expect_colon;
      logic             in_ipv4;
      logic [2:0]       octet_count;
      logic             failed;
   } snap_type;

   function automatic logic is_decimal(input logic [7:0] c);
      return (c >= CHAR_0) && (c <= CHAR_9);
   endfunction

   // Returns {is_hex, value}.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if ((c >= CHAR_0) && (c <= CHAR_9)) begin
         d = c - CHAR_0;
         return {1'b1, d[3:0]};
      end
      if ((c >= CHAR_LA) && (c <= CHAR_LF)) begin
         d = c - CHAR_LA + 8'd10;
         return {1'b1, d[3:0]};
      end
      if ((c >= CHAR_UA) && (c <= CHAR_UF)) begin
         d = c - CHAR_UA + 8'd10;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/ipv6tp_char_parser.sv @@
// Character stage of the IPv6 text parser: input register and per-character state update.
// Depends on ipv6tp_pkg. Hands a snapshot of the state to the finisher on the last beat.
`default_nettype none

module ipv6tp_char_parser (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire  [7:0]            req_tdata,   // char_code
   input  wire                   req_tlast,   // last_char
   output logic                  snap_valid,
   input  wire                   snap_ready,
   output ipv6tp_pkg::snap_type  snap
);
   import ipv6tp_pkg::*;

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       char_ff;
   logic             last_ff;
   logic             take;

   logic [15:0][7:0] bytes_ff, bytes_in, bytes_p;
   logic [4:0]       wp_ff, wp_in, wp_p;
   logic [4:0]       gp_ff, gp_in, gp_p;
   logic             gap_ff, gap_in, gap_p;
   logic [15:0]      gv_ff, gv_in, gv_p;
   logic             ghd_ff, ghd_in, ghd_p;
   logic [8:0]       td_ff, td_in, td_p;
   logic             tad_ff, tad_in, tad_p;
   logic             first_ff, first_in, first_p;
   logic             esc_ff, esc_in, esc_p;
   logic             v4_ff, v4_in, v4_p;
   logic [7:0]       ov_ff, ov_in, ov_p;
   logic [2:0]       oc_ff, oc_in, oc_p;
   logic             ohd_ff, ohd_in, ohd_p;
   logic             fail_ff, fail_in, fail_p;

   logic [4:0]       hex;
   logic             dec;
   logic [11:0]      oct_sum;
   logic [11:0]      tok_sum;
   logic [2:0]       oc_new;
   logic [2:0]       oc_m1;
   logic [3:0]       oct_idx;
   logic [3:0]       wp_lo;

   assign take        = in_valid_ff && (!last_ff || snap_ready);
   assign req_tready  = !in_valid_ff || take;
   assign in_valid_in = req_tvalid || (in_valid_ff && !take);
   assign snap_valid  = in_valid_ff && last_ff;

   assign hex     = hex_digit(char_ff);
   assign dec     = is_decimal(char_ff);
   assign oct_sum = ({4'd0, ov_ff} << 3) + ({4'd0, ov_ff} << 1) + {8'd0, hex[3:0]};
   assign tok_sum = ({3'd0, td_ff} << 3) + ({3'd0, td_ff} << 1) + {8'd0, hex[3:0]};
   assign oc_new  = ohd_ff ? oc_ff : oc_ff + 3'd1;
   assign oc_m1   = oc_new - 3'd1;
   assign wp_lo   = wp_ff[3:0];
   assign oct_idx = wp_lo + {2'd0, oc_m1[1:0]};

   // Post-character state; a failure freezes the rest, since the string is lost anyway.
   always_comb begin
      bytes_p = bytes_ff; wp_p = wp_ff; gp_p = gp_ff; gap_p = gap_ff;
      gv_p = gv_ff; ghd_p = ghd_ff; td_p = td_ff; tad_p = tad_ff;
      first_p = first_ff; esc_p = esc_ff; v4_p = v4_ff; ov_p = ov_ff;
      oc_p = oc_ff; ohd_p = ohd_ff; fail_p = fail_ff;
      if (!fail_ff) begin
         first_p = 1'b0;
         if (first_ff && (char_ff == CHAR_COLON)) begin
            esc_p = 1'b1;
         end else if (esc_ff && (char_ff != CHAR_COLON)) begin
            esc_p  = 1'b0;
            fail_p = 1'b1;
         end else if (char_ff == CHAR_NUL) begin
            esc_p  = 1'b0;
            fail_p = 1'b1;
         end else begin
            esc_p = 1'b0;
            if (v4_ff) begin
               if (dec) begin
                  if (oct_sum > {3'd0, OCTET_MAX}) begin
                     fail_p = 1'b1;
                  end else if (!ohd_ff && (oc_ff >= OCTETS_V4)) begin
                     fail_p = 1'b1;
                  end else begin
                     ov_p             = oct_sum[7:0];
                     oc_p             = oc_new;
                     ohd_p            = 1'b1;
                     bytes_p[oct_idx] = oct_sum[7:0];
                  end
               end else if ((char_ff == CHAR_DOT) && ohd_ff) begin
                  if (oc_ff == OCTETS_V4) begin
                     fail_p = 1'b1;
                  end else begin
                     ov_p  = 8'd0;
                     ohd_p = 1'b0;
                  end
               end else begin
                  fail_p = 1'b1;
               end
            end else if (hex[4]) begin
               if (gv_ff[15:12] != 4'd0) begin
                  fail_p = 1'b1;
               end else begin
                  gv_p  = {gv_ff[11:0], hex[3:0]};
                  ghd_p = 1'b1;
                  if (dec) begin
                     if (td_ff <= OCTET_MAX) begin
                        td_p = (tok_sum > {3'd0, OCTET_MAX}) ? TOKEN_SAT : tok_sum[8:0];
                     end
                  end else begin
                     tad_p = 1'b0;
                  end
               end
            end else if (char_ff == CHAR_COLON) begin
               td_p  = 9'd0;
               tad_p = 1'b1;
               if (!ghd_ff) begin
                  if (gap_ff) begin
                     fail_p = 1'b1;
                  end else begin
                     gap_p = 1'b1;
                     gp_p  = wp_ff;
                  end
               end else if (last_ff || (wp_ff > POS_LAST_GRP)) begin
                  fail_p = 1'b1;
               end else begin
                  bytes_p[wp_lo]        = gv_ff[15:8];
                  bytes_p[wp_lo + 4'd1] = gv_ff[7:0];
                  wp_p  = wp_ff + 5'd2;
                  gv_p  = 16'd0;
                  ghd_p = 1'b0;
               end
            end else if ((char_ff == CHAR_DOT) && ghd_ff && tad_ff &&
                         (td_ff <= OCTET_MAX) && (wp_ff <= POS_LAST_V4)) begin
               bytes_p[wp_lo] = td_ff[7:0];
               v4_p  = 1'b1;
               oc_p  = 3'd1;
               ov_p  = 8'd0;
               ohd_p = 1'b0;
               ghd_p = 1'b0;
            end else begin
               fail_p = 1'b1;
            end
         end
      end
   end

   // Advance on each consumed beat; restart from the reset values after the last one.
   always_comb begin
      bytes_in = bytes_ff; wp_in = wp_ff; gp_in = gp_ff; gap_in = gap_ff;
      gv_in = gv_ff; ghd_in = ghd_ff; td_in = td_ff; tad_in = tad_ff;
      first_in = first_ff; esc_in = esc_ff; v4_in = v4_ff; ov_in = ov_ff;
      oc_in = oc_ff; ohd_in = ohd_ff; fail_in = fail_ff;
      if (take) begin
         bytes_in = bytes_p;
         if (last_ff) begin
            wp_in = 5'd0; gp_in = 5'd0; gap_in = 1'b0; gv_in = 16'd0; ghd_in = 1'b0;
            td_in = 9'd0; tad_in = 1'b1; first_in = 1'b1; esc_in = 1'b0; v4_in = 1'b0;
            ov_in = 8'd0; oc_in = 3'd0; ohd_in = 1'b0; fail_in = 1'b0;
         end else begin
            wp_in = wp_p; gp_in = gp_p; gap_in = gap_p; gv_in = gv_p; ghd_in = ghd_p;
            td_in = td_p; tad_in = tad_p; first_in = first_p; esc_in = esc_p;
            v4_in = v4_p; ov_in = ov_p; oc_in = oc_p; ohd_in = ohd_p; fail_in = fail_p;
         end
      end
   end

   always_comb begin
      snap.bytes           = bytes_p;
      snap.write_pos       = wp_p;
      snap.gap_pos         = gp_p;
      snap.gap_seen        = gap_p;
      snap.group_value     = gv_p;
      snap.group_has_digit = ghd_p;
      snap.expect_colon    = esc_p;
      snap.in_ipv4         = v4_p;
      snap.octet_count     = oc_p;
      snap.failed          = fail_p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         wp_ff <= 5'd0; gp_ff <= 5'd0; gap_ff <= 1'b0; gv_ff <= 16'd0; ghd_ff <= 1'b0;
         td_ff <= 9'd0; tad_ff <= 1'b1; first_ff <= 1'b1; esc_ff <= 1'b0; v4_ff <= 1'b0;
         ov_ff <= 8'd0; oc_ff <= 3'd0; ohd_ff <= 1'b0; fail_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         wp_ff <= wp_in; gp_ff <= gp_in; gap_ff <= gap_in; gv_ff <= gv_in; ghd_ff <= ghd_in;
         td_ff <= td_in; tad_ff <= tad_in; first_ff <= first_in; esc_ff <= esc_in;
         v4_ff <= v4_in; ov_ff <= ov_in; oc_ff <= oc_in; ohd_ff <= ohd_in;
         fail_ff <= fail_in;
      end
   end

   // Payload: input beat and address bytes carry no reset.
   always_ff @(posedge clock) begin
      if (req_tready) begin
         char_ff <= req_tdata;
         last_ff <= req_tlast;
      end
      bytes_ff <= bytes_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/ipv6tp_gap_expander.sv @@
// Finishing stage of the IPv6 text parser: closes the last group, expands the gap
// and holds the result register. Depends on ipv6tp_pkg.
`default_nettype none

module ipv6tp_gap_expander (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   snap_valid,
   output logic                  snap_ready,
   input  ipv6tp_pkg::snap_type  snap,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [127:0]          rsp_tdata,   // address_high, address_low
   output logic                  rsp_tuser    // valid_res
);
   import ipv6tp_pkg::*;

   logic             fin_valid_ff, fin_valid_in;
   snap_type         fin_ff;
   logic             fin_move;
   logic             out_valid_ff, out_valid_in;
   logic [127:0]     data_ff;
   logic             ok_ff;

   logic [15:0][7:0] bytes_f;
   logic [15:0][7:0] moved;
   logic [4:0]       wp_f;
   logic [3:0]       wp_lo;
   logic             ok;
   logic [5:0]       reach;
   logic [127:0]     data_in;

   assign fin_move     = fin_valid_ff && (!out_valid_ff || rsp_tready);
   assign snap_ready   = !fin_valid_ff || fin_move;
   assign fin_valid_in = snap_valid || (fin_valid_ff && !fin_move);
   assign out_valid_in = fin_move || (out_valid_ff && !rsp_tready);
   assign wp_lo        = fin_ff.write_pos[3:0];

   always_comb begin
      bytes_f = fin_ff.bytes;
      wp_f    = fin_ff.write_pos;
      ok      = !fin_ff.failed && !fin_ff.expect_colon;
      reach   = 6'd0;
      if (fin_ff.in_ipv4) begin
         if (fin_ff.octet_count < OCTETS_V4) ok = 1'b0;
         wp_f = fin_ff.write_pos + 5'd4;
      end else if (fin_ff.group_has_digit) begin
         if (fin_ff.write_pos > POS_LAST_GRP) ok = 1'b0;
         bytes_f[wp_lo]        = fin_ff.group_value[15:8];
         bytes_f[wp_lo + 4'd1] = fin_ff.group_value[7:0];
         wp_f = fin_ff.write_pos + 5'd2;
      end
      if (wp_f > POS_FULL) ok = 1'b0;
      moved = bytes_f;
      if (fin_ff.gap_seen && (wp_f != POS_FULL)) begin
         if (fin_ff.gap_pos > wp_f) ok = 1'b0;
         // Keep bytes ahead of the gap, slide the tail to the end, zero the hole.
         for (int j = 0; j < ADDR_BYTES; j++) begin
            reach = 6'(j) + {1'b0, wp_f};
            if (5'(j) < fin_ff.gap_pos) begin
               moved[j] = bytes_f[j];
            end else if (reach >= ({1'b0, fin_ff.gap_pos} + 6'd16)) begin
               moved[j] = bytes_f[4'(j) + wp_f[3:0]];
            end else begin
               moved[j] = 8'd0;
            end
         end
      end else if (wp_f != POS_FULL) begin
         ok = 1'b0;
      end
      for (int i = 0; i < 8; i++) begin
         data_in[8*(7-i) +: 8]      = ok ? moved[i]     : 8'd0;
         data_in[64 + 8*(7-i) +: 8] = ok ? moved[i + 8] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_ready) begin
         fin_ff <= snap;
      end
      if (fin_move) begin
         data_ff <= data_in;
         ok_ff   <= ok;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = ok_ff;

endmodule

`default_nettype wire

@@ rtl/core/ipv6_address_text_parser_core.sv @@
// Top level of the IPv6 address text parser: character stage and finishing stage.
// Depends on ipv6tp_pkg, ipv6tp_char_parser and ipv6tp_gap_expander.
//
//   channel  direction  ports                         payload
//   req      in         req_tvalid/tready/tdata/tlast  char_code, last_char
//   rsp      out        rsp_tvalid/tready/tdata/tuser  address bytes, valid_res
//
// One character is taken per cycle; the per-character state update in the
// character stage sets that figure. A result passes through the finishing register
// and the result register onto rsp. Reset is synchronous and clears all control state.
// Characters keep flowing while a result waits on rsp; only a further last beat
// holds, until the finishing register frees up.
`default_nettype none

module ipv6_address_text_parser_core (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,   // char_code
   input  wire          req_tlast,   // last_char
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [127:0] rsp_tdata,   // address_high [63:0], address_low [127:64]
   output logic         rsp_tuser    // valid_res
);
   import ipv6tp_pkg::*;

   snap_type snap;
   logic     snap_valid;
   logic     snap_ready;

   ipv6tp_char_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   ipv6tp_gap_expander u_expander (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
